FILE: rtl/pwmenc_pkg.sv
// Shared types and constants for the PWM encoder angle/speed unit.
// Holds the microcode word layout, the control program table and config indexes.
// No dependencies.
package pwmenc_pkg;

  // Default angle resolution, bits per turn
  localparam int ANGLE_BITS_DEF = 16;

  // Field widths fixed by the interface
  localparam int PULSE_BITS = 20;
  localparam int TICK_BITS  = 32;
  localparam int FRAC_BITS  = 16;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 16;

  // Config register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_ABI_ENABLE = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ABI_TOP    = 1'd1;

  // Sequencer program size
  localparam int PC_BITS   = 4;

  // Datapath action of one step
  typedef enum logic [3:0] {
    A_NOP,
    A_IDLE,
    A_ADIV_INIT,
    A_DIV_STEP,
    A_CAPTURE,
    A_SPD_STORE,
    A_PRELOAD,
    A_RD_MUL,
    A_RD_SUM,
    A_EMIT
  } action_t;

  // Jump condition of one step; jump to target when true, else fall through
  typedef enum logic [2:0] {
    C_NONE,
    C_ALWAYS,
    C_NO_ITEM,
    C_READ,
    C_PERR,
    C_CNT_NZ,
    C_NO_SPEED,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    action_t              action;
    cond_t                cond;
    logic [PC_BITS-1:0]   target;
  } ctrl_word_t;

  // Program addresses
  localparam logic [PC_BITS-1:0] PC_IDLE     = 4'd0;
  localparam logic [PC_BITS-1:0] PC_DISPATCH = 4'd1;
  localparam logic [PC_BITS-1:0] PC_ADIV     = 4'd2;
  localparam logic [PC_BITS-1:0] PC_ALOOP    = 4'd3;
  localparam logic [PC_BITS-1:0] PC_CAPTURE  = 4'd4;
  localparam logic [PC_BITS-1:0] PC_SLOOP    = 4'd5;
  localparam logic [PC_BITS-1:0] PC_SSTORE   = 4'd6;
  localparam logic [PC_BITS-1:0] PC_PRELOAD  = 4'd7;
  localparam logic [PC_BITS-1:0] PC_RD_MUL   = 4'd8;
  localparam logic [PC_BITS-1:0] PC_RD_SUM   = 4'd9;
  localparam logic [PC_BITS-1:0] PC_EMIT     = 4'd15;

  // Control program; the emit step sits at the last address so the
  // step counter wraps back to idle after it
  function automatic ctrl_word_t rom_word(input logic [PC_BITS-1:0] pc);
    ctrl_word_t w;
    case (pc)
      PC_IDLE:     w = '{A_IDLE,      C_NO_ITEM,  PC_IDLE};
      PC_DISPATCH: w = '{A_NOP,       C_READ,     PC_RD_MUL};
      PC_ADIV:     w = '{A_ADIV_INIT, C_PERR,     PC_EMIT};
      PC_ALOOP:    w = '{A_DIV_STEP,  C_CNT_NZ,   PC_ALOOP};
      PC_CAPTURE:  w = '{A_CAPTURE,   C_NO_SPEED, PC_PRELOAD};
      PC_SLOOP:    w = '{A_DIV_STEP,  C_CNT_NZ,   PC_SLOOP};
      PC_SSTORE:   w = '{A_SPD_STORE, C_NONE,     PC_IDLE};
      PC_PRELOAD:  w = '{A_PRELOAD,   C_ALWAYS,   PC_EMIT};
      PC_RD_MUL:   w = '{A_RD_MUL,    C_NONE,     PC_IDLE};
      PC_RD_SUM:   w = '{A_RD_SUM,    C_ALWAYS,   PC_EMIT};
      PC_EMIT:     w = '{A_EMIT,      C_OUT_BUSY, PC_EMIT};
      default:     w = '{A_NOP,       C_ALWAYS,   PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/pwm_encoder_angle_speed_unit.sv
// PWM absolute encoder decoder: angle, speed, extrapolated angle, ABI preload.
// Microcoded sequencer over a shared restoring divider and two multipliers.
// Depends on pwmenc_pkg.
//
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_stall    op, pulse_width, pulse_period, now_ticks
// out       output     out_valid / out_stall  angle_frac, speed, extrapolated_angle,
//                                             abi_preload, abi_preload_valid,
//                                             capture_count, period_error
// cfg       input      cfg_write              cfg_index, cfg_data
//
// Path to the result register: a capture runs the angle division, then the speed
// division but for the first two captures; a read multiplies and adds; a capture
// with zero period goes straight to emit. Divider: one quotient bit per cycle.
// A new item is taken once the sequencer is back at idle, while the previous
// result may still wait in the output register; a stalled output holds the emit step.
// rst is synchronous, active high; it clears state, config and the sequencer.
module pwm_encoder_angle_speed_unit #(
  parameter int ANGLE_BITS = pwmenc_pkg::ANGLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 op,
  input  logic [pwmenc_pkg::PULSE_BITS-1:0]    pulse_width,
  input  logic [pwmenc_pkg::PULSE_BITS-1:0]    pulse_period,
  input  logic [pwmenc_pkg::TICK_BITS-1:0]     now_ticks,
  // output channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [pwmenc_pkg::FRAC_BITS-1:0]     angle_frac,
  output logic signed [pwmenc_pkg::TICK_BITS-1:0] speed,
  output logic [pwmenc_pkg::FRAC_BITS-1:0]     extrapolated_angle,
  output logic [pwmenc_pkg::FRAC_BITS-1:0]     abi_preload,
  output logic                                 abi_preload_valid,
  output logic [pwmenc_pkg::TICK_BITS-1:0]     capture_count,
  output logic                                 period_error,
  // config port
  input  logic                                 cfg_write,
  input  logic [pwmenc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [pwmenc_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  localparam int SHIFT = pwmenc_pkg::TICK_BITS - ANGLE_BITS;
  localparam int TB    = pwmenc_pkg::TICK_BITS;
  localparam int PB    = pwmenc_pkg::PULSE_BITS;
  localparam int FB    = pwmenc_pkg::FRAC_BITS;
  localparam int CNT_BITS = $clog2(TB);

  // Angle to 16-bit turn fraction
  function automatic logic [FB-1:0] frac16(input logic [ANGLE_BITS-1:0] a);
    logic [TB-1:0] t;
    t = {a, {SHIFT{1'b0}}};
    return t[TB-1 -: FB];
  endfunction

  // Sequencer
  logic [pwmenc_pkg::PC_BITS-1:0] pc;
  logic [pwmenc_pkg::PC_BITS-1:0] pc_next;
  pwmenc_pkg::ctrl_word_t         ctrl;
  logic                           jump;
  logic [CNT_BITS-1:0]            cnt;

  // Latched item
  logic            op_r;
  logic [PB-1:0]   width_r;
  logic [PB-1:0]   period_r;
  logic [TB-1:0]   now_r;

  // Shared divider: remainder, dividend/quotient shifter, divisor
  logic [TB:0]     rem;
  logic [TB-1:0]   dq;
  logic [TB-1:0]   dsr;
  logic            neg_r;

  // Block state
  logic [ANGLE_BITS-1:0] last_angle;
  logic [TB-1:0]         speed_est;
  logic [TB-1:0]         last_ts;
  logic [TB-1:0]         captures;
  logic                  abi_enable;
  logic [FB-1:0]         abi_top;

  // Work registers
  logic [TB-1:0]   prod;
  logic [FB-1:0]   ext_r;
  logic [FB-1:0]   preload_r;
  logic            pvalid_r;
  logic            perr_r;

  // Datapath combinational terms
  logic [TB:0]           rem_shift;
  logic                  rem_ge;
  logic [TB:0]           rem_step;
  logic [ANGLE_BITS-1:0] ang_new;
  logic [ANGLE_BITS-1:0] ang_diff;
  logic [TB-1:0]         scaled;
  logic [TB-1:0]         mag;
  logic [TB-1:0]         dt;
  logic [TB-1:0]         captures_inc;
  logic [ANGLE_BITS+FB-1:0] preload_prod;
  logic [TB-1:0]         ext_sum;
  logic                  out_busy;

  assign in_stall = rst || (pc != pwmenc_pkg::PC_IDLE);
  assign out_busy = out_valid && out_stall;

  // One divider step: shift in next dividend bit, subtract when it fits
  always_comb begin
    rem_shift = {rem[TB-1:0], dq[TB-1]};
    rem_ge    = (rem_shift >= {1'b0, dsr});
    rem_step  = rem_ge ? (rem_shift - {1'b0, dsr}) : rem_shift;
  end

  // Datapath terms: new angle, wrapped difference, elapsed ticks, preload product, read sum
  always_comb begin
    ang_new      = dq[ANGLE_BITS-1:0];
    ang_diff     = ang_new - last_angle;
    scaled       = {ang_diff, {SHIFT{1'b0}}};
    mag          = scaled[TB-1] ? (~scaled + 1'b1) : scaled;
    dt           = now_r - last_ts;
    captures_inc = captures + 1'b1;
    preload_prod = last_angle * abi_top;
    ext_sum      = {last_angle, {SHIFT{1'b0}}} + prod;
  end

  // Next step
  always_comb begin
    ctrl = pwmenc_pkg::rom_word(pc);
    case (ctrl.cond)
      pwmenc_pkg::C_NONE:     jump = 1'b0;
      pwmenc_pkg::C_ALWAYS:   jump = 1'b1;
      pwmenc_pkg::C_NO_ITEM:  jump = !in_valid;
      pwmenc_pkg::C_READ:     jump = op_r;
      pwmenc_pkg::C_PERR:     jump = (period_r == '0);
      pwmenc_pkg::C_CNT_NZ:   jump = (cnt != '0);
      pwmenc_pkg::C_NO_SPEED: jump = (captures_inc <= TB'(2));
      pwmenc_pkg::C_OUT_BUSY: jump = out_busy;
      default:                jump = 1'b0;
    endcase
    pc_next = jump ? ctrl.target : (pc + 1'b1);
  end

  // State, datapath and output registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pc         <= pwmenc_pkg::PC_IDLE;
      out_valid  <= 1'b0;
      last_angle <= '0;
      speed_est  <= '0;
      last_ts    <= '0;
      captures   <= '0;
      abi_enable <= 1'b0;
      abi_top    <= '0;
    end else begin
      pc <= pc_next;

      // config writes
      if (cfg_write) begin
        case (cfg_index)
          pwmenc_pkg::REG_ABI_ENABLE: abi_enable <= cfg_data[0];
          pwmenc_pkg::REG_ABI_TOP:    abi_top    <= cfg_data;
          default: ;
        endcase
      end

      // output register drains; the emit step reloads it itself
      if (out_valid && !out_stall && ctrl.action != pwmenc_pkg::A_EMIT) begin
        out_valid <= 1'b0;
      end

      case (ctrl.action)
        pwmenc_pkg::A_IDLE: begin
          if (in_valid) begin
            op_r      <= op;
            width_r   <= pulse_width;
            period_r  <= pulse_period;
            now_r     <= now_ticks;
            preload_r <= '0;
            pvalid_r  <= 1'b0;
            perr_r    <= !op && (pulse_period == '0);
          end
        end
        pwmenc_pkg::A_ADIV_INIT: begin
          // width at or above period gives a full turn, which wraps to zero
          rem <= (width_r >= period_r) ? '0 : (TB+1)'(width_r);
          dq  <= '0;
          dsr <= TB'(period_r);
          cnt <= CNT_BITS'(ANGLE_BITS - 1);
        end
        pwmenc_pkg::A_DIV_STEP: begin
          rem <= rem_step;
          dq  <= {dq[TB-2:0], rem_ge};
          if (cnt != '0) begin
            cnt <= cnt - 1'b1;
          end
        end
        pwmenc_pkg::A_CAPTURE: begin
          // set up speed division from old state, then commit new state
          rem        <= '0;
          dq         <= mag;
          dsr        <= (dt == '0) ? TB'(1) : dt;
          neg_r      <= scaled[TB-1];
          cnt        <= CNT_BITS'(TB - 1);
          captures   <= captures_inc;
          last_ts    <= now_r;
          last_angle <= ang_new;
        end
        pwmenc_pkg::A_SPD_STORE: begin
          speed_est <= neg_r ? (~dq + 1'b1) : dq;
        end
        pwmenc_pkg::A_PRELOAD: begin
          pvalid_r  <= abi_enable;
          preload_r <= abi_enable ? preload_prod[ANGLE_BITS +: FB] : '0;
        end
        pwmenc_pkg::A_RD_MUL: begin
          prod <= speed_est * dt;
        end
        pwmenc_pkg::A_RD_SUM: begin
          ext_r <= frac16(ext_sum[TB-1:SHIFT]);
        end
        pwmenc_pkg::A_EMIT: begin
          if (!out_busy) begin
            out_valid          <= 1'b1;
            angle_frac         <= frac16(last_angle);
            speed              <= speed_est;
            extrapolated_angle <= op_r ? ext_r : frac16(last_angle);
            abi_preload        <= preload_r;
            abi_preload_valid  <= pvalid_r;
            capture_count      <= captures;
            period_error       <= perr_r;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: tb/pwm_encoder_angle_speed_unit_test.sv
// Self-checking bench for pwm_encoder_angle_speed_unit: angle, speed, extrapolation and preload.
// Runs directed corner items, then random capture/read sequences over several register settings.
// Depends on pwmenc_pkg and the unit's RTL.
module pwm_encoder_angle_speed_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pwmenc_pkg::*;

  localparam int ANG_BITS = ANGLE_BITS_DEF;
  localparam int ANG_SHIFT = 32 - ANG_BITS;
  localparam logic [31:0] ANG_MASK = 32'((64'd1 << ANG_BITS) - 1);

  localparam logic OP_CAPTURE = 1'b0;
  localparam logic OP_READ    = 1'b1;

  localparam int IDLE_PCT     = 6;
  localparam int PHASE_ITEMS  = 255;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 64;
  localparam int CYCLE_LIMIT  = 1000000;

  // one result item of the unit
  typedef struct packed {
    logic [FRAC_BITS-1:0] angle;
    logic [TICK_BITS-1:0] speed;
    logic [FRAC_BITS-1:0] ext;
    logic [FRAC_BITS-1:0] preload;
    logic                 preload_ok;
    logic [TICK_BITS-1:0] count;
    logic                 period_err;
  } report_t;

  // Tracks encoder state, predicts each result item and checks the unit's output
  class encoder_scoreboard;
    logic        abi_enable;
    logic [15:0] abi_top;
    logic [31:0] angle_q;
    logic [31:0] speed_q;
    logic [31:0] stamp_q;
    logic [31:0] count_q;
    report_t     expected_reports[$];
    int          errors;

    function new();
      abi_enable = 1'b0;
      abi_top = '0;
      angle_q = '0;
      speed_q = '0;
      stamp_q = '0;
      count_q = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      if (idx == REG_ABI_ENABLE) begin
        abi_enable = data[0];
      end else if (idx == REG_ABI_TOP) begin
        abi_top = data;
      end
    endfunction

    // angle in ANG_BITS per turn, scaled to a 16-bit turn fraction
    function logic [15:0] frac16(logic [31:0] a);
      return 16'(((a & ANG_MASK) << ANG_SHIFT) >> 16);
    endfunction

    // predict the result of one accepted item and advance the tracked state
    function void decode_item(logic kind, logic [PULSE_BITS-1:0] width,
                              logic [PULSE_BITS-1:0] period, logic [TICK_BITS-1:0] stamp);
      report_t     r;
      logic [31:0] span;
      logic [31:0] lead;
      logic [31:0] mag;
      logic [31:0] quot;
      logic [31:0] sum;
      logic [31:0] new_angle;
      logic [PULSE_BITS-1:0] hi;
      r = '0;
      if (kind == OP_READ) begin
        span = stamp - stamp_q;
        sum = (angle_q << ANG_SHIFT) + speed_q * span;
        r.ext = frac16(sum >> ANG_SHIFT);
      end else if (period == '0) begin
        r.period_err = 1'b1;
        r.ext = frac16(angle_q);
      end else begin
        hi = (width < period) ? width : period;
        new_angle = 32'((64'(hi) << ANG_BITS) / period) & ANG_MASK;
        count_q = count_q + 1;
        // speed only from the third good capture on
        if (count_q > 2) begin
          lead = ((new_angle - angle_q) & ANG_MASK) << ANG_SHIFT;
          mag = lead[31] ? -lead : lead;
          span = stamp - stamp_q;
          if (span == 0) span = 1;
          quot = mag / span;
          speed_q = lead[31] ? -quot : quot;
        end
        stamp_q = stamp;
        angle_q = new_angle;
        if (abi_enable) begin
          r.preload_ok = 1'b1;
          r.preload = 16'((64'(new_angle) * abi_top) >> ANG_BITS);
        end
        r.ext = frac16(angle_q);
      end
      r.angle = frac16(angle_q);
      r.speed = speed_q;
      r.count = count_q;
      expected_reports.push_back(r);
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
      end
    endfunction

    function void check_report(report_t got);
      report_t want;
      if (expected_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual angle %0h count %0h",
                 $time, got.angle, got.count);
        return;
      end
      want = expected_reports.pop_front();
      compare("angle_frac", 32'(want.angle), 32'(got.angle));
      compare("speed", want.speed, got.speed);
      compare("extrapolated_angle", 32'(want.ext), 32'(got.ext));
      compare("abi_preload", 32'(want.preload), 32'(got.preload));
      compare("abi_preload_valid", 32'(want.preload_ok), 32'(got.preload_ok));
      compare("capture_count", want.count, got.count);
      compare("period_error", 32'(want.period_err), 32'(got.period_err));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     op = OP_CAPTURE;
  logic [PULSE_BITS-1:0]    pulse_width = '0;
  logic [PULSE_BITS-1:0]    pulse_period = '0;
  logic [TICK_BITS-1:0]     now_ticks = '0;

  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [FRAC_BITS-1:0]     angle_frac;
  logic signed [TICK_BITS-1:0] speed;
  logic [FRAC_BITS-1:0]     extrapolated_angle;
  logic [FRAC_BITS-1:0]     abi_preload;
  logic                     abi_preload_valid;
  logic [TICK_BITS-1:0]     capture_count;
  logic                     period_error;

  logic                     cfg_write = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = REG_ABI_ENABLE;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  encoder_scoreboard sb = new();

  logic        calm = 1'b0;
  int          hold_requests = 0;
  int          holds_taken = 0;
  int          hold_left = 0;
  int          cycle_count = 0;
  logic [31:0] tick_now = '0;

  pwm_encoder_angle_speed_unit uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .pulse_width(pulse_width),
    .pulse_period(pulse_period),
    .now_ticks(now_ticks),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .angle_frac(angle_frac),
    .speed(speed),
    .extrapolated_angle(extrapolated_angle),
    .abi_preload(abi_preload),
    .abi_preload_valid(abi_preload_valid),
    .capture_count(capture_count),
    .period_error(period_error),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver: random stalls, long hold-off on request, none while calm
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (holds_taken != hold_requests) begin
      holds_taken <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && !out_stall)
      sb.check_report('{angle_frac, speed, extrapolated_angle, abi_preload,
                        abi_preload_valid, capture_count, period_error});
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[pwm_encoder_angle_speed_unit] ERROR");
    $finish;
  end

  function automatic logic [PULSE_BITS-1:0] pick_period();
    int roll;
    roll = $urandom_range(99);
    if (roll < 60) return PULSE_BITS'($urandom_range(1, 4095));
    if (roll < 90) return PULSE_BITS'($urandom_range(1, 20'hFFFFF));
    case ($urandom_range(2))
      0: return 20'd1;
      1: return 20'd2;
      default: return 20'hFFFFF;
    endcase
  endfunction

  function automatic logic [31:0] pick_span();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return 32'($urandom_range(0, 2000));
    if (roll < 90) return 32'($urandom_range(0, 1 << 20));
    return $urandom;
  endfunction

  // offer one item, optionally after a gap; valid stays high after acceptance
  task automatic offer(input logic kind, input logic [PULSE_BITS-1:0] width,
                       input logic [PULSE_BITS-1:0] period, input logic [TICK_BITS-1:0] stamp);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= kind;
    pulse_width <= width;
    pulse_period <= period;
    now_ticks <= stamp;
    do @(posedge clk); while (in_stall);
    sb.decode_item(kind, width, period, stamp);
  endtask

  // write both registers on consecutive edges while the unit is idle
  task automatic program_regs(input logic enable, input logic [15:0] top);
    cfg_write <= 1'b1;
    cfg_index <= REG_ABI_ENABLE;
    cfg_data <= CFG_DATA_BITS'(enable);
    @(posedge clk);
    sb.write_reg(REG_ABI_ENABLE, CFG_DATA_BITS'(enable));
    cfg_index <= REG_ABI_TOP;
    cfg_data <= top;
    @(posedge clk);
    sb.write_reg(REG_ABI_TOP, top);
    cfg_write <= 1'b0;
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_reports.size() != 0) @(posedge clk);
  endtask

  initial begin
    int phase;
    int pick;
    logic kind;
    logic [PULSE_BITS-1:0] width;
    logic [PULSE_BITS-1:0] period;
    logic [TICK_BITS-1:0] stamp;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    program_regs(1'b1, 16'hFFFF);

    // directed corners
    offer(OP_READ, 20'd0, 20'd0, 32'd12345);                    // read from reset state
    offer(OP_CAPTURE, 20'hFFFFF, 20'd0, 32'hFFFFFFFF);          // zero period, nothing stored
    offer(OP_CAPTURE, 20'd0, 20'd1, 32'd100);                   // angle zero
    offer(OP_CAPTURE, 20'hFFFFF, 20'hFFFFF, 32'd200);           // full turn wraps to zero
    offer(OP_CAPTURE, 20'hFFFFF, 20'd1, 32'd200);               // width over period, no elapsed ticks
    offer(OP_CAPTURE, 20'd1, 20'd2, 32'd1200);                  // exactly half a turn
    offer(OP_READ, 20'hFFFFF, 20'hFFFFF, 32'd1700);
    offer(OP_CAPTURE, 20'd1, 20'd4, 32'd1300);                  // backward step
    offer(OP_CAPTURE, 20'd3, 20'd4, 32'hFFFFFF00);
    offer(OP_CAPTURE, 20'd1, 20'hFFFFF, 32'h00000010);          // timestamp wraps
    offer(OP_READ, 20'd0, 20'd0, 32'h00000010);                 // read with no elapsed ticks
    offer(OP_READ, 20'd0, 20'd0, 32'hFFFFFFFF);
    offer(OP_CAPTURE, 20'h7FFFF, 20'hFFFFF, 32'h00000011);
    offer(OP_CAPTURE, 20'h80000, 20'hFFFFF, 32'h80000011);
    offer(OP_CAPTURE, 20'd0, 20'd0, 32'd5);                     // both zero
    offer(OP_READ, 20'hFFFFF, 20'd0, 32'h80001011);
    offer(OP_CAPTURE, 20'hAAAAA, 20'h55555, 32'h55555555);
    offer(OP_CAPTURE, 20'h55555, 20'hAAAAA, 32'hAAAAAAAA);
    tick_now = 32'hAAAAAAAA;
    drain();

    // random phases, each under its own register setting
    for (phase = 0; phase < 6; phase++) begin
      calm <= (phase == 3);
      if (phase == 1) hold_requests <= hold_requests + 1;
      case (phase)
        0: program_regs(1'b1, 16'h0000);
        1: program_regs(1'b0, 16'h3039);
        2: program_regs(1'b1, 16'h0001);
        3: program_regs(1'b1, 16'($urandom));
        4: program_regs(1'b1, 16'hFFFF);
        default: program_regs(1'($urandom), 16'($urandom));
      endcase
      repeat (PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 50) begin
          // well-formed capture stream
          period = pick_period();
          width = PULSE_BITS'($urandom_range(0, period));
          tick_now = tick_now + pick_span();
          offer(OP_CAPTURE, width, period, tick_now);
        end else if (pick < 75) begin
          tick_now = tick_now + pick_span();
          offer(OP_READ, PULSE_BITS'($urandom), PULSE_BITS'($urandom), tick_now);
        end else if (pick < 83) begin
          // arbitrary width against period
          tick_now = tick_now + pick_span();
          offer(OP_CAPTURE, PULSE_BITS'($urandom), PULSE_BITS'($urandom), tick_now);
        end else if (pick < 88) begin
          offer(OP_CAPTURE, PULSE_BITS'($urandom), '0, $urandom);
        end else if (pick < 95) begin
          kind = 1'($urandom);
          stamp = $urandom;
          offer(kind, PULSE_BITS'($urandom), PULSE_BITS'($urandom), stamp);
          tick_now = stamp;
        end else begin
          // repeated timestamp
          period = pick_period();
          width = PULSE_BITS'($urandom_range(0, period));
          offer(OP_CAPTURE, width, period, tick_now);
        end
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_reports.size() == 0) begin
      $display("[pwm_encoder_angle_speed_unit] OK");
    end else begin
      $display("[pwm_encoder_angle_speed_unit] ERROR");
    end
    $finish;
  end

endmodule
